### rtl/scope_profiler_accumulator_assert.svh
// Assertion macros used by the profiler back end (spa_back).
// Included by modules that check their own control logic.
`ifndef SCOPE_PROFILER_ACCUMULATOR_ASSERT_SVH
`define SCOPE_PROFILER_ACCUMULATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SPA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define SPA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/spa_pkg.sv
// Package of the scope profiler: widths, command, status and operation codes, queue entry type, back-end states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spa_pkg;
    localparam int NUM_REGIONS = 16;
    localparam int TIME_BITS   = 48;
    localparam int REG_BITS    = 4;
    localparam int CNT_BITS    = 32;
    localparam int OUT_BITS    = 48;

    typedef enum logic [1:0] {
        CMD_ENTER = 2'd0,
        CMD_EXIT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OPEN     = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_ROOT     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_ENTER,
        OP_EXIT,
        OP_READ
    } op_t;

    // One classified transaction on its way to the table.
    typedef struct packed {
        op_t                   op;
        status_t               status;
        logic [REG_BITS-1:0]   region;
        logic [TIME_BITS-1:0]  ts;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_PARENT,
        BK_OUT
    } bk_state_t;
endpackage
`default_nettype wire

### rtl/spa_front.sv
// Front end: accepts commands and tags each one with the operation to run.
// Depends on spa_pkg. Error checks needing table state are done in the back end.
`timescale 1ns / 1ps
`default_nettype none
module spa_front import spa_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_cmd,
    input  wire logic [3:0]           s_region,
    input  wire logic [47:0]          s_timestamp,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output job_t                      q_job
);
    // Two-entry queue.
    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    job_t       job;
    logic       push, pop;

    always_comb begin
        job.region = s_region[REG_BITS-1:0];
        job.ts     = s_timestamp[TIME_BITS-1:0];
        job.status = ST_OK;
        job.op     = OP_NOP;
        if (s_cmd != CMD_NONE && (s_region == 4'd0 || 32'(s_region) >= NUM_REGIONS)) begin
            job.status = ST_ROOT;
        end else begin
            case (s_cmd)
                CMD_ENTER: job.op = OP_ENTER;
                CMD_EXIT:  job.op = OP_EXIT;
                CMD_READ:  job.op = OP_READ;
                default:   job.op = OP_NOP;
            endcase
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= job;
        end
    end
endmodule
`default_nettype wire

### rtl/spa_back.sv
// Back end: executes one queued command against the region table.
// Depends on spa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "scope_profiler_accumulator_assert.svh"
module spa_back import spa_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire job_t             q_job,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [1:0]            m_status,
    output logic [31:0]           m_count,
    output logic [47:0]           m_total_ticks,
    output logic [47:0]           m_self_ticks
);
    localparam int RB = REG_BITS;
    localparam int TB = TIME_BITS;

    logic [RB-1:0]       cur_reg, cur_next;
    logic [NUM_REGIONS-1:0] open_reg;
    logic [RB-1:0]       parent_reg  [NUM_REGIONS];
    logic [CNT_BITS-1:0] inv_reg     [NUM_REGIONS];
    logic [TB-1:0]       start_reg   [NUM_REGIONS];
    logic [TB-1:0]       child_reg   [NUM_REGIONS];
    logic [TB-1:0]       total_reg   [NUM_REGIONS];
    logic [TB-1:0]       self_reg    [NUM_REGIONS];

    bk_state_t state_reg, state_next;
    job_t      job_reg;
    logic [TB-1:0] elapsed_reg;
    logic [RB-1:0] par_reg;
    logic [1:0]    st_reg;
    logic [31:0]   cnt_o_reg;
    logic [47:0]   tot_o_reg, slf_o_reg;

    logic [TB-1:0] elapsed;
    logic [RB-1:0] r;

    assign r       = job_reg.region;
    assign elapsed = job_reg.ts - start_reg[r];
    assign q_ready = (state_reg == BK_IDLE);
    assign m_valid = (state_reg == BK_OUT);
    assign m_status      = st_reg;
    assign m_count       = cnt_o_reg;
    assign m_total_ticks = tot_o_reg;
    assign m_self_ticks  = slf_o_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:   if (q_valid) state_next = BK_EXEC;
            BK_EXEC:   state_next = (job_reg.op == OP_EXIT && cur_reg == r
                                     && parent_reg[r] != '0) ? BK_PARENT : BK_OUT;
            BK_PARENT: state_next = BK_OUT;
            BK_OUT:    if (m_ready) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        cur_next = cur_reg;
        if (state_reg == BK_EXEC) begin
            if (job_reg.op == OP_ENTER && !open_reg[r]) begin
                cur_next = r;
            end else if (job_reg.op == OP_EXIT && cur_reg == r) begin
                cur_next = parent_reg[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            cur_reg   <= '0;
            open_reg  <= '0;
            for (int i = 0; i < NUM_REGIONS; i++) begin
                parent_reg[i] <= '0;
                inv_reg[i]    <= '0;
                child_reg[i]  <= '0;
                total_reg[i]  <= '0;
                self_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            if (state_reg == BK_EXEC) begin
                if (job_reg.op == OP_ENTER && !open_reg[r]) begin
                    open_reg[r]   <= 1'b1;
                    parent_reg[r] <= cur_reg;
                    inv_reg[r]    <= inv_reg[r] + 32'd1;
                    child_reg[r]  <= '0;
                end else if (job_reg.op == OP_EXIT && cur_reg == r) begin
                    open_reg[r]  <= 1'b0;
                    total_reg[r] <= total_reg[r] + elapsed;
                    self_reg[r]  <= self_reg[r] + elapsed - child_reg[r];
                end
            end else if (state_reg == BK_PARENT) begin
                // The parent's child ticks are updated in the cycle after the exit.
                child_reg[par_reg] <= child_reg[par_reg] + elapsed_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BK_IDLE && q_valid) begin
            job_reg <= q_job;
        end
        if (state_reg == BK_EXEC) begin
            elapsed_reg <= elapsed;
            par_reg     <= parent_reg[r];
            if (job_reg.op == OP_ENTER && open_reg[r]) begin
                st_reg <= ST_OPEN;
            end else if (job_reg.op == OP_EXIT && cur_reg != r) begin
                st_reg <= ST_MISMATCH;
            end else begin
                st_reg <= job_reg.status;
            end
            if (job_reg.op == OP_ENTER && !open_reg[r]) begin
                start_reg[r] <= job_reg.ts;
            end
            if (job_reg.op == OP_READ) begin
                cnt_o_reg <= inv_reg[r];
                tot_o_reg <= 48'(total_reg[r]);
                slf_o_reg <= 48'(self_reg[r]);
            end else begin
                cnt_o_reg <= '0;
                tot_o_reg <= '0;
                slf_o_reg <= '0;
            end
        end
    end

    `SPA_ASSERT_IMPL(a_cur_open, aclk, aresetn, cur_reg != '0, open_reg[cur_reg])
    `SPA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status))
    `SPA_ASSERT_NEXT(a_parent_step, aclk, aresetn, state_reg == BK_PARENT, state_reg == BK_OUT)
endmodule
`default_nettype wire

### rtl/scope_profiler_accumulator.sv
// Hierarchical scope profiler: command in, one status/counter result out per command.
//
// Input channel s_*: cmd (enter, exit, read), region, timestamp, valid/ready.
// Result channel m_*: status, count, total_ticks, self_ticks, valid/ready.
// Every transaction yields exactly one result, in order.
// A front end classifies commands into a two-entry queue; the back end
// runs one command at a time against the region table held in flip-flops.
// The back end's sequencer steps each command through IDLE, EXEC and OUT,
// adding a PARENT state after EXEC for an exit whose parent is not the root;
// it takes the next command only in IDLE, after the result handshake of the
// previous one.
// Reset clears the table at once except the start times, which each enter writes; no clearing pass is needed.
// When the receiver stalls the result holds, the back end waits, and the
// front queue keeps taking up to two more transactions.
`timescale 1ns / 1ps
`default_nettype none
module scope_profiler_accumulator import spa_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [3:0]  s_region,
    input  wire logic [47:0] s_timestamp,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_count,
    output logic [47:0]      m_total_ticks,
    output logic [47:0]      m_self_ticks
);
    logic q_valid, q_ready;
    job_t q_job;

    spa_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_region, .s_timestamp,
        .q_valid, .q_ready, .q_job
    );

    spa_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_job, .m_valid, .m_ready,
        .m_status, .m_count, .m_total_ticks, .m_self_ticks
    );
endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench of the scope profiler table: drives enter, exit, read and no-op commands
// and checks every status/counter result against an in-bench profile model.
// Depends on spa_pkg and the scope_profiler_accumulator RTL.
`timescale 1ns / 1ps
module testbench;
    import spa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1630;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  region;
        logic [47:0] ts;
    } prof_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] count;
        logic [47:0] total;
        logic [47:0] self_t;
    } prof_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = '0;
    logic [3:0]  s_region = '0;
    logic [47:0] s_timestamp = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_count;
    logic [47:0] m_total_ticks;
    logic [47:0] m_self_ticks;

    scope_profiler_accumulator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_region(s_region), .s_timestamp(s_timestamp),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_count(m_count), .m_total_ticks(m_total_ticks), .m_self_ticks(m_self_ticks)
    );

    always #5 aclk = ~aclk;

    // Profile model state.
    logic [3:0]  cur_region;
    logic [3:0]  parent_tbl [16];
    logic        open_tbl   [16];
    logic [31:0] calls_tbl  [16];
    logic [47:0] start_tbl  [16];
    logic [47:0] child_tbl  [16];
    logic [47:0] total_tbl  [16];
    logic [47:0] self_tbl   [16];

    prof_cmd_t pending_cmds[$];
    prof_res_t expected_results[$];
    int        mismatches = 0;
    int        n_results = 0;
    int        n_sent = 0;
    int        n_ok_exit = 0;
    int        n_ok_read = 0;
    int        n_errors = 0;
    int        cycles = 0;
    bit        stim_done = 1'b0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    bit        drain_pause = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;
    logic [47:0] clock_ts = 48'd1000;

    function automatic prof_res_t profile_step(prof_cmd_t c);
        prof_res_t   r;
        logic [47:0] el;
        logic [3:0]  p;
        r = '0;
        if (c.cmd != CMD_NONE && c.region == 4'd0) begin
            r.status = ST_ROOT;
        end else if (c.cmd == CMD_ENTER) begin
            if (open_tbl[c.region]) begin
                r.status = ST_OPEN;
            end else begin
                open_tbl[c.region] = 1'b1;
                parent_tbl[c.region] = cur_region;
                cur_region = c.region;
                calls_tbl[c.region] += 32'd1;
                start_tbl[c.region] = c.ts;
                child_tbl[c.region] = '0;
            end
        end else if (c.cmd == CMD_EXIT) begin
            if (c.region != cur_region) begin
                r.status = ST_MISMATCH;
            end else begin
                el = c.ts - start_tbl[c.region];
                p = parent_tbl[c.region];
                if (p != 4'd0) child_tbl[p] = child_tbl[p] + el;
                total_tbl[c.region] = total_tbl[c.region] + el;
                self_tbl[c.region] = self_tbl[c.region] + el - child_tbl[c.region];
                open_tbl[c.region] = 1'b0;
                cur_region = p;
            end
        end else if (c.cmd == CMD_READ) begin
            r.count = calls_tbl[c.region];
            r.total = total_tbl[c.region];
            r.self_t = self_tbl[c.region];
        end
        return r;
    endfunction

    // Tracks which regions the stimulus believes are open, so that most exits target the
    // innermost region entered earlier; the other exits use random regions.
    logic [3:0] gen_stack[$];

    function automatic logic [47:0] next_ts();
        if ($urandom_range(0, 19) == 0) clock_ts = 48'({$urandom, $urandom});
        else clock_ts = clock_ts + $urandom_range(0, 5000);
        return clock_ts;
    endfunction

    function automatic void push_cmd(logic [1:0] c, logic [3:0] r, logic [47:0] t);
        prof_cmd_t x;
        x.cmd = c; x.region = r; x.ts = t;
        if (c == CMD_ENTER && r != 0) begin
            if (!(r inside {gen_stack})) gen_stack.push_back(r);
        end else if (c == CMD_EXIT && gen_stack.size() > 0 && r == gen_stack[$]) begin
            void'(gen_stack.pop_back());
        end
        pending_cmds.push_back(x);
    endfunction

    function automatic void random_cmd();
        int k;
        logic [3:0] r;
        k = $urandom_range(0, 99);
        if (k < 40) begin
            r = 4'($urandom_range(1, 15));
            push_cmd(CMD_ENTER, r, next_ts());
        end else if (k < 72) begin
            if (gen_stack.size() > 0) push_cmd(CMD_EXIT, gen_stack[$], next_ts());
            else push_cmd(CMD_EXIT, 4'($urandom_range(0, 15)), next_ts());
        end else if (k < 90) begin
            push_cmd(CMD_READ, 4'($urandom_range(0, 15)), 48'({$urandom, $urandom}));
        end else if (k < 96) begin
            // Exit of a random region, which need not be the innermost open one.
            push_cmd(CMD_EXIT, 4'($urandom_range(0, 15)), next_ts());
        end else begin
            push_cmd(CMD_NONE, 4'($urandom_range(0, 15)), 48'({$urandom, $urandom}));
        end
    endfunction

    initial begin
        cur_region = '0;
        for (int i = 0; i < 16; i++) begin
            parent_tbl[i] = '0; open_tbl[i] = 1'b0; calls_tbl[i] = '0; start_tbl[i] = '0;
            child_tbl[i] = '0; total_tbl[i] = '0; self_tbl[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: root use, recursion, mismatch, nesting, wrap of timestamps, reads.
        push_cmd(CMD_ENTER, 4'd0, 48'd5);
        push_cmd(CMD_EXIT, 4'd0, 48'd5);
        push_cmd(CMD_READ, 4'd0, 48'd0);
        push_cmd(CMD_READ, 4'd15, 48'hFFFF_FFFF_FFFF);
        push_cmd(CMD_EXIT, 4'd3, 48'd7);
        push_cmd(CMD_ENTER, 4'd15, 48'hFFFF_FFFF_FFF0);
        push_cmd(CMD_ENTER, 4'd15, 48'd1);
        push_cmd(CMD_ENTER, 4'd1, 48'hFFFF_FFFF_FFFF);
        push_cmd(CMD_EXIT, 4'd15, 48'd3);
        push_cmd(CMD_ENTER, 4'd2, 48'd20);
        push_cmd(CMD_EXIT, 4'd2, 48'd50);
        push_cmd(CMD_EXIT, 4'd1, 48'd100);
        push_cmd(CMD_EXIT, 4'd15, 48'd200);
        push_cmd(CMD_READ, 4'd15, 48'd0);
        push_cmd(CMD_READ, 4'd1, 48'd0);
        push_cmd(CMD_READ, 4'd2, 48'd0);
        push_cmd(CMD_NONE, 4'd15, 48'hFFFF_FFFF_FFFF);
        push_cmd(CMD_NONE, 4'd0, 48'd0);
        push_cmd(CMD_ENTER, 4'd8, 48'd0);
        push_cmd(CMD_EXIT, 4'd8, 48'hFFFF_FFFF_FFFF);
        push_cmd(CMD_READ, 4'd8, 48'd0);

        for (int i = 0; i < N_RANDOM; i++) begin
            random_cmd();
            if (i == 900) begin
                wait (pending_cmds.size() == 0);
                drain_pause = 1'b1;
                wait (expected_results.size() == 0);
                repeat (10) @(posedge aclk);
                drain_pause = 1'b0;
            end
        end
        wait (pending_cmds.size() == 0 && !s_valid);
        stim_done = 1'b1;
    end

    // Driver: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(profile_step({s_cmd, s_region, s_timestamp}));
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0 && !drain_pause) begin
                    prof_cmd_t x;
                    x = pending_cmds.pop_front();
                    s_valid <= 1'b1;
                    s_cmd <= x.cmd;
                    s_region <= x.region;
                    s_timestamp <= x.ts;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver hold-off: once 400 transactions are in, results are refused for a single
    // stretch while the sender keeps offering.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
        end else if (!hold_done && n_sent >= 400) begin
            hold_left = 300;
            hold_done = 1'b1;
        end
    end

    // Monitor and receiver stall pattern.
    always @(posedge aclk) begin
        prof_res_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Result with no command outstanding");
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.status == ST_OK && m_count != 0) n_ok_read++;
                    if (exp_r.status != ST_OK) n_errors++;
                    if (m_status !== exp_r.status || m_count !== exp_r.count ||
                        m_total_ticks !== exp_r.total || m_self_ticks !== exp_r.self_t) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: exp st=%0d cnt=%0d tot=%0d self=%0d, ",
                                      "got st=%0d cnt=%0d tot=%0d self=%0d"},
                                     exp_r.status, exp_r.count, exp_r.total, exp_r.self_t,
                                     m_status, m_count, m_total_ticks, m_self_ticks);
                    end
                end
            end
            if (hold_left > 0) m_ready <= 1'b0;
            else if ((cycles / 64) % 4 == 3) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge aclk);
        $display("Ran %0d commands, %0d results; %0d error statuses, %0d nonzero reads.",
                 n_sent, n_results, n_errors, n_ok_read);
        $display("Covered nesting, wrapped timestamps, a long result stall and a full drain.");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/spa_pkg.sv
rtl/spa_front.sv
rtl/spa_back.sv
rtl/scope_profiler_accumulator.sv
tb/sv/testbench.sv
